// ----- hdl/dse_pkg.sv -----
// Package for the dose schedule evaluator: payload structs, constants and
// the command/status structs between controller and datapath. No dependencies.
package dse_pkg;

   localparam int MAX_SLOTS_DEF      = 16;
   localparam int MAX_CYCLE_DAYS_DEF = 30;
   localparam int SCAN_DAYS_DEF      = 61;

   localparam logic [31:0] SEC_PER_DAY   = 32'd86400;
   localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
   localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;
   localparam logic [2:0]  WEEK_LEN      = 3'd7;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_EVAL  = 1'b1;

   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_WMASK  = 3'd1;
   localparam logic [2:0] REG_CYCLE  = 3'd2;
   localparam logic [2:0] REG_ANCHOR = 3'd3;
   localparam logic [2:0] REG_SLOTS  = 3'd4;
   localparam logic [2:0] REG_GRACE  = 3'd5;

   typedef struct packed {
      logic        func;
      logic [3:0]  slot_index;
      logic [10:0] slot_minute;
      logic [15:0] slot_amount;
      logic [15:0] local_day;
      logic [10:0] now_minute;
      logic [15:0] fired_bits;
      logic [15:0] skip_bits;
   } req_type;

   typedef struct packed {
      logic        day_active;
      logic        due_found;
      logic [3:0]  due_slot;
      logic [15:0] missed_bits;
      logic        next_found;
      logic [31:0] next_time;
      logic [15:0] next_amount;
      logic [19:0] today_total;
   } rsp_type;

   typedef struct packed {
      logic        schedule_mode;
      logic [6:0]  week_day_mask;
      logic [4:0]  cycle_days;
      logic [15:0] cycle_anchor_day;
      logic [4:0]  slots_in_use;
      logic [7:0]  grace_window;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request, reset accumulators
      logic day_start; // begin active test of current scan day
      logic mod_step;  // one restoring-division step of the phase
      logic day_eval;  // latch active flag of current scan day
      logic slot_step; // process current slot
      logic day_next;  // advance scan day
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic mod_done;
      logic day_ok;
      logic last_slot;
      logic hit;
      logic no_slots;
      logic last_day;
   } sts_type;

endpackage

// ----- hdl/dose_schedule_evaluator.sv -----
// Top level of the dose schedule evaluator: APB register file, controller
// and datapath. Depends on dse_pkg, dse_controller and dse_datapath.
//
// A write transaction (func 0) stores one dose slot and gives no result. An
// evaluate transaction (func 1) is accepted, then walks the scan days one at
// a time; each day has a setup state, 17 steps of the serial modulo unit for
// the every-N-days phase and a check that it has finished, a state to latch
// the day test, one slot step per active slot (one pass through the slot
// state when no slot is active) and an advance state, for up to SCAN_DAYS
// days, ending early when a dose is found or no slot is active. The result is
// held until taken; the next transaction is accepted after that. Registers
// sit at byte address 4*i: mode, weekday mask, cycle days, anchor day, slots
// in use, grace.
module dose_schedule_evaluator #(
   parameter int MAX_SLOTS = dse_pkg::MAX_SLOTS_DEF,
   parameter int SCAN_DAYS = dse_pkg::SCAN_DAYS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dse_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import dse_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   sts_type sts;
   logic    wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];

   // register write at the access phase
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_idx)
            REG_MODE:   cfg_in.schedule_mode    = csr_pwdata[0];
            REG_WMASK:  cfg_in.week_day_mask    = csr_pwdata[6:0];
            REG_CYCLE:  cfg_in.cycle_days       = csr_pwdata[4:0];
            REG_ANCHOR: cfg_in.cycle_anchor_day = csr_pwdata[15:0];
            REG_SLOTS:  cfg_in.slots_in_use     = csr_pwdata[4:0];
            REG_GRACE:  cfg_in.grace_window     = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MODE:   csr_prdata = {31'b0, cfg_ff.schedule_mode};
         REG_WMASK:  csr_prdata = {25'b0, cfg_ff.week_day_mask};
         REG_CYCLE:  csr_prdata = {27'b0, cfg_ff.cycle_days};
         REG_ANCHOR: csr_prdata = {16'b0, cfg_ff.cycle_anchor_day};
         REG_SLOTS:  csr_prdata = {27'b0, cfg_ff.slots_in_use};
         REG_GRACE:  csr_prdata = {24'b0, cfg_ff.grace_window};
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{schedule_mode: 1'b0, week_day_mask: 7'd127, cycle_days: 5'd1,
                     cycle_anchor_day: 16'd0, slots_in_use: 5'd0, grace_window: 8'd30};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dse_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_data.func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd),
      .wr_en     (wr_en)
   );

   dse_datapath #(.MAX_SLOTS(MAX_SLOTS), .SCAN_DAYS(SCAN_DAYS)) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .wr_en  (wr_en),
      .req    (req_data),
      .cmd    (cmd),
      .sts    (sts),
      .rsp    (rsp_data)
   );
endmodule

// ----- hdl/dse_datapath.sv -----
// Datapath of the dose schedule evaluator: slot table, day test with a
// serial modulo unit, slot walk, accumulators. Depends on dse_pkg.
module dse_datapath #(
   parameter int MAX_SLOTS = dse_pkg::MAX_SLOTS_DEF,
   parameter int SCAN_DAYS = dse_pkg::SCAN_DAYS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  dse_pkg::cfg_type cfg,
   input  logic             wr_en,
   input  dse_pkg::req_type req,
   input  dse_pkg::cmd_type cmd,
   output dse_pkg::sts_type sts,
   output dse_pkg::rsp_type rsp
);
   import dse_pkg::*;

   localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int OW = $clog2(SCAN_DAYS + 1);
   localparam int NW = $clog2(MAX_SLOTS + 1);

   logic [10:0] minutes_mem [MAX_SLOTS];
   logic [15:0] amounts_mem [MAX_SLOTS];

   logic [NW-1:0] n_act;
   assign n_act = (cfg.slots_in_use > 5'(MAX_SLOTS)) ? NW'(MAX_SLOTS)
                                                      : NW'(cfg.slots_in_use);

   always_ff @(posedge clock) begin
      if (wr_en && ({1'b0, req.slot_index} < 5'(MAX_SLOTS))) begin
         minutes_mem[req.slot_index[SW-1:0]] <= req.slot_minute;
         amounts_mem[req.slot_index[SW-1:0]] <= req.slot_amount;
      end
   end

   logic [10:0] now_ff;
   logic [15:0] fired_ff, pend_ff, pend_in, missed_ff, missed_in;
   logic [OW-1:0] off_ff, off_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [16:0] cur_day_ff, cur_day_in;
   logic [19:0] total_ff, total_in;
   logic due_found_ff, due_found_in, active0_ff, active0_in;
   logic [3:0] due_slot_ff, due_slot_in;
   logic day_ok_ff, day_ok_in;
   logic next_found_ff, next_found_in;
   logic [31:0] next_time_ff, next_time_in;
   logic [15:0] next_amount_ff, next_amount_in;
   // restoring division of |day-anchor| by cycle_days, one bit a step
   logic [16:0] rem_ff, rem_in;
   logic [16:0] quo_ff, quo_in;
   logic [4:0]  mcnt_ff, mcnt_in;
   // slot table read registered at the next slot address
   logic [10:0] m_rd_ff;
   logic [15:0] a_rd_ff;

   logic [10:0] m_cur;
   logic [15:0] a_cur;
   logic [11:0] end_min;
   logic [15:0] bit_cur;
   logic [16:0] day_gap;
   logic [16:0] trial;
   logic [2:0]  wd;
   logic [17:0] wsum;
   logic [5:0]  oct_sum1;
   logic [3:0]  oct_sum2;
   logic [3:0]  oct_sum3;
   logic        cand;

   always_comb begin
      m_cur   = m_rd_ff;
      a_cur   = a_rd_ff;
      end_min = {1'b0, m_cur} + {4'b0, cfg.grace_window};
      bit_cur = 16'(1) << slot_ff;
      day_gap = (cur_day_ff >= {1'b0, cfg.cycle_anchor_day})
              ? cur_day_ff - {1'b0, cfg.cycle_anchor_day}
              : {1'b0, cfg.cycle_anchor_day} - cur_day_ff;
      trial   = {rem_ff[15:0], quo_ff[16]};
      // weekday by folding octal digits, since 8 is 1 modulo 7
      wsum     = 18'(cur_day_ff) + 18'(EPOCH_WEEKDAY);
      oct_sum1 = {3'b0, wsum[2:0]} + {3'b0, wsum[5:3]} + {3'b0, wsum[8:6]}
               + {3'b0, wsum[11:9]} + {3'b0, wsum[14:12]} + {3'b0, wsum[17:15]};
      oct_sum2 = {1'b0, oct_sum1[2:0]} + {1'b0, oct_sum1[5:3]};
      oct_sum3 = {1'b0, oct_sum2[2:0]} + {3'b0, oct_sum2[3]};
      wd       = (oct_sum3 == 4'd7) ? 3'd0 : oct_sum3[2:0];
      cand    = !((off_ff == '0) && ((m_cur < now_ff) || ((fired_ff & bit_cur) != '0)));

      pend_in = pend_ff; missed_in = missed_ff; off_in = off_ff;
      slot_in = slot_ff; cur_day_in = cur_day_ff; total_in = total_ff;
      due_found_in = due_found_ff; due_slot_in = due_slot_ff; day_ok_in = day_ok_ff;
      next_found_in = next_found_ff; next_time_in = next_time_ff;
      next_amount_in = next_amount_ff; rem_in = rem_ff; quo_in = quo_ff;
      mcnt_in = mcnt_ff; active0_in = active0_ff;

      if (cmd.load) begin
         cur_day_in = {1'b0, req.local_day}; pend_in = req.skip_bits;
         missed_in = '0; off_in = '0; slot_in = '0; total_in = '0;
         due_found_in = 1'b0; due_slot_in = '0; next_found_in = 1'b0;
         next_time_in = '0; next_amount_in = '0;
      end
      if (cmd.day_start) begin
         rem_in = '0; quo_in = day_gap; mcnt_in = '0;
      end
      if (cmd.mod_step) begin
         if (trial >= {12'b0, cfg.cycle_days}) begin
            rem_in = trial - {12'b0, cfg.cycle_days};
            quo_in = {quo_ff[15:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[15:0], 1'b0};
         end
         mcnt_in = mcnt_ff + 5'd1;
      end
      if (cmd.day_eval) begin
         if (cfg.schedule_mode) day_ok_in = cfg.week_day_mask[wd];
         else if (cfg.cycle_days <= 5'd1) day_ok_in = 1'b1;
         else day_ok_in = (rem_ff == '0);
         if (off_ff == '0) active0_in = day_ok_in;
         slot_in = '0;
      end
      if (cmd.slot_step) begin
         if (off_ff == '0) begin
            if (!due_found_ff && !fired_ff[slot_ff] && (now_ff >= m_cur)
                && ({1'b0, now_ff} < end_min)) begin
               due_found_in = 1'b1; due_slot_in = 4'(slot_ff);
            end
            if ({1'b0, now_ff} >= end_min) missed_in = missed_ff | bit_cur;
            total_in = total_ff + 20'(a_cur);
         end
         if (day_ok_ff && !next_found_ff && cand) begin
            if ((pend_ff & bit_cur) != '0) pend_in = pend_ff & ~bit_cur;
            else begin
               next_found_in = 1'b1;
               next_amount_in = a_cur;
               next_time_in = 32'(cur_day_ff) * SEC_PER_DAY
                            + 32'(m_cur) * 32'(SEC_PER_MIN);
            end
         end
         slot_in = slot_ff + SW'(1);
      end
      if (cmd.day_next) begin
         cur_day_in = cur_day_ff + 17'd1; off_in = off_ff + OW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mcnt_ff <= '0;
      end else begin
         mcnt_ff <= mcnt_in;
      end
      pend_ff <= pend_in; missed_ff <= missed_in; off_ff <= off_in;
      slot_ff <= slot_in; cur_day_ff <= cur_day_in; total_ff <= total_in;
      due_found_ff <= due_found_in; due_slot_ff <= due_slot_in; day_ok_ff <= day_ok_in;
      next_found_ff <= next_found_in; next_time_ff <= next_time_in;
      next_amount_ff <= next_amount_in; rem_ff <= rem_in; quo_ff <= quo_in;
      active0_ff <= active0_in;
      m_rd_ff <= minutes_mem[slot_in];
      a_rd_ff <= amounts_mem[slot_in];
      if (cmd.load) begin
         now_ff <= req.now_minute; fired_ff <= req.fired_bits;
      end
   end

   // scan day is 17 bits wide: day plus offset may pass 65535
   assign sts.mod_done  = (mcnt_ff == 5'd17);
   assign sts.day_ok    = day_ok_ff;
   assign sts.last_slot = ({1'b0, slot_ff} == NW'(n_act - NW'(1))) || (n_act == '0);
   assign sts.hit       = next_found_ff;
   assign sts.no_slots  = (n_act == '0);
   assign sts.last_day  = (off_ff == OW'(SCAN_DAYS - 1));

   always_comb begin
      rsp.day_active  = active0_ff;
      rsp.due_found   = due_found_ff;
      rsp.due_slot    = due_slot_ff;
      rsp.missed_bits = missed_ff;
      rsp.next_found  = next_found_ff;
      rsp.next_time   = next_time_ff;
      rsp.next_amount = next_amount_ff;
      rsp.today_total = active0_ff ? total_ff : '0;
   end
endmodule

// ----- hdl/dse_controller.sv -----
// Controller of the dose schedule evaluator: sequences the day scan and the
// result handshake. Depends on dse_pkg.
module dse_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_func,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  dse_pkg::sts_type sts,
   output dse_pkg::cmd_type cmd,
   output logic             wr_en
);
   import dse_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_MOD   = 3'd2;
   localparam logic [2:0] ST_EVAL  = 3'd3;
   localparam logic [2:0] ST_SLOT  = 3'd4;
   localparam logic [2:0] ST_NEXT  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       take;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign take      = req_valid && req_ready;
   assign wr_en     = take && (req_func == FUNC_WRITE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && req_func == FUNC_EVAL) begin
               cmd.load = 1'b1; state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.day_start = 1'b1; state_in = ST_MOD;
         end
         ST_MOD: begin
            if (sts.mod_done) state_in = ST_EVAL;
            else cmd.mod_step = 1'b1;
         end
         ST_EVAL: begin
            cmd.day_eval = 1'b1; state_in = ST_SLOT;
         end
         ST_SLOT: begin
            // first day always walks all slots for due/missed/total
            if (!sts.no_slots) cmd.slot_step = 1'b1;
            if (sts.last_slot) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (sts.no_slots || sts.hit || sts.last_day) state_in = ST_DONE;
            else begin
               cmd.day_next = 1'b1; state_in = ST_START;
            end
         end
         ST_DONE: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for dose_schedule_evaluator: drives slot writes and evaluations,
// predicts every result in place and checks it. Depends on dse_pkg and the RTL.
module testbench;
   import dse_pkg::*;

   localparam int SLOT_CNT   = 16;
   localparam int SCAN_SPAN  = 61;
   localparam int SETTLE     = 20;
   localparam int HOLD_SPAN  = 400;
   localparam longint LIMIT  = 6_000_000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dose_schedule_evaluator dut (.*);

   // Shadow of the block: configuration and the dose slot table
   cfg_type     sched_cfg;
   logic [10:0] slot_min_tbl [SLOT_CNT];
   logic [15:0] slot_amt_tbl [SLOT_CNT];

   rsp_type pending_doses[$];
   int      err_cnt;
   longint  cycle_cnt;
   int      send_idle_pct;
   int      recv_stall_pct;
   bit      hold_request;
   int      hold_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort on a hang
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Day test: weekday mask, or every-N-days phase by absolute distance
   function automatic bit day_is_dosing(input logic [31:0] day);
      logic [31:0] day_gap;
      if (sched_cfg.schedule_mode)
         return sched_cfg.week_day_mask[(day + 32'd4) % 32'd7];
      if (sched_cfg.cycle_days <= 5'd1)
         return 1'b1;
      day_gap = (day >= sched_cfg.cycle_anchor_day) ? day - sched_cfg.cycle_anchor_day
                                                    : sched_cfg.cycle_anchor_day - day;
      return (day_gap % sched_cfg.cycle_days) == 0;
   endfunction

   // Work out the full evaluation of one request against the shadow state
   function automatic rsp_type eval_schedule(input req_type rq);
      rsp_type     r;
      int          n;
      logic [15:0] skips;
      logic [31:0] d;
      logic [31:0] total;
      r = '0;
      total = 0;
      skips = rq.skip_bits;
      n = (sched_cfg.slots_in_use > SLOT_CNT) ? SLOT_CNT : sched_cfg.slots_in_use;
      r.day_active = day_is_dosing({16'd0, rq.local_day});
      for (int i = 0; i < n; i++) begin
         if (!r.due_found && !rq.fired_bits[i] && rq.now_minute >= slot_min_tbl[i] &&
             32'(rq.now_minute) < 32'(slot_min_tbl[i]) + sched_cfg.grace_window) begin
            r.due_found = 1'b1;
            r.due_slot  = 4'(i);
         end
         if (32'(rq.now_minute) >= 32'(slot_min_tbl[i]) + sched_cfg.grace_window)
            r.missed_bits[i] = 1'b1;
         total += slot_amt_tbl[i];
      end
      r.today_total = r.day_active ? total[19:0] : 20'd0;
      for (int off = 0; off < SCAN_SPAN && !r.next_found && n > 0; off++) begin
         d = 32'(rq.local_day) + 32'(off);
         if (!day_is_dosing(d)) continue;
         for (int i = 0; i < n; i++) begin
            if (off == 0 && (slot_min_tbl[i] < rq.now_minute || rq.fired_bits[i]))
               continue;
            if (skips[i]) begin
               skips[i] = 1'b0;
               continue;
            end
            r.next_found  = 1'b1;
            r.next_time   = d * 32'd86400 + 32'(slot_min_tbl[i]) * 32'd60;
            r.next_amount = slot_amt_tbl[i];
            break;
         end
      end
      return r;
   endfunction

   // Send one transaction; update the shadow or queue a result when accepted
   task automatic send_item(input req_type rq);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      if (rq.func == FUNC_WRITE) begin
         slot_min_tbl[rq.slot_index] = rq.slot_minute;
         slot_amt_tbl[rq.slot_index] = rq.slot_amount;
      end else
         pending_doses.push_back(eval_schedule(rq));
   endtask

   function automatic req_type slot_write(input int idx, input int minute, input int amt);
      req_type rq;
      rq = '0;
      rq.func        = FUNC_WRITE;
      rq.slot_index  = 4'(idx);
      rq.slot_minute = 11'(minute);
      rq.slot_amount = 16'(amt);
      return rq;
   endfunction

   function automatic req_type eval_req(input int day, input int now,
                                        input int fired, input int skip);
      req_type rq;
      rq = '0;
      rq.func       = FUNC_EVAL;
      rq.local_day  = 16'(day);
      rq.now_minute = 11'(now);
      rq.fired_bits = 16'(fired);
      rq.skip_bits  = 16'(skip);
      return rq;
   endfunction

   // Drop valid and let every expected result come out, then let writes settle
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_doses.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Setup and access phase; the write lands on the edge with penable high
   task automatic csr_write(input logic [2:0] reg_id, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_id, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (reg_id)
         REG_MODE:   sched_cfg.schedule_mode    = value[0];
         REG_WMASK:  sched_cfg.week_day_mask    = value[6:0];
         REG_CYCLE:  sched_cfg.cycle_days       = value[4:0];
         REG_ANCHOR: sched_cfg.cycle_anchor_day = value[15:0];
         REG_SLOTS:  sched_cfg.slots_in_use     = value[4:0];
         REG_GRACE:  sched_cfg.grace_window     = value[7:0];
         default: ;
      endcase
   endtask

   // Receiver: random stall, or a long hold when a test asks for one
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_SPAN;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         err_cnt++;
      end
   endtask

   // Compare every accepted result with the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_doses.size() == 0) begin
            $error("result transaction with nothing expected");
            err_cnt++;
         end else begin
            exp_r = pending_doses.pop_front();
            check_field("day_active",  exp_r.day_active,  rsp_data.day_active);
            check_field("due_found",   exp_r.due_found,   rsp_data.due_found);
            check_field("due_slot",    exp_r.due_slot,    rsp_data.due_slot);
            check_field("missed_bits", exp_r.missed_bits, rsp_data.missed_bits);
            check_field("next_found",  exp_r.next_found,  rsp_data.next_found);
            check_field("next_time",   exp_r.next_time,   rsp_data.next_time);
            check_field("next_amount", exp_r.next_amount, rsp_data.next_amount);
            check_field("today_total", exp_r.today_total, rsp_data.today_total);
         end
      end
   end

   // Fill the whole table with the extremes, then hit the corner settings
   task automatic test_directed;
      send_item(eval_req(0, 0, 0, 0));           // no active slots: no next dose
      for (int i = 0; i < SLOT_CNT; i++)
         send_item(slot_write(i, (i == 0) ? 0 : (i == 15) ? 1439 : i * 90,
                              (i == 15) ? 65535 : (i == 0) ? 0 : i * 1000));
      drain();
      csr_write(REG_SLOTS, 16);
      csr_write(REG_GRACE, 255);
      send_item(eval_req(0, 0, 0, 16'hffff));    // skip every first occurrence
      send_item(eval_req(65535, 1439, 16'hffff, 0));
      drain();
      csr_write(REG_SLOTS, 31);                  // saturates to the table size
      csr_write(REG_GRACE, 0);
      csr_write(REG_MODE, 1);
      csr_write(REG_WMASK, 0);                   // never a dosing day
      send_item(eval_req(1234, 600, 0, 0));
      drain();
      csr_write(REG_MODE, 0);
      csr_write(REG_CYCLE, 31);
      csr_write(REG_ANCHOR, 65535);              // anchor ahead of the day
      send_item(eval_req(0, 700, 16'h00ff, 16'hff00));
      drain();
      csr_write(REG_CYCLE, 0);
      csr_write(REG_ANCHOR, 0);
      send_item(eval_req(100, 1439, 0, 0));
      drain();
   endtask

   task automatic random_config;
      csr_write(REG_MODE,   $urandom_range(1));
      csr_write(REG_WMASK,  ($urandom_range(9) == 0) ? 0 :
                            ($urandom_range(4) == 0) ? 127 : $urandom_range(127));
      csr_write(REG_CYCLE,  $urandom_range(31));
      csr_write(REG_ANCHOR, ($urandom_range(7) == 0) ? 65535 : $urandom_range(65535));
      csr_write(REG_SLOTS,  ($urandom_range(9) == 0) ? $urandom_range(31)
                                                     : $urandom_range(16, 1));
      csr_write(REG_GRACE,  ($urandom_range(7) == 0) ? 255 : $urandom_range(255));
   endtask

   function automatic req_type random_item;
      if ($urandom_range(3) == 0)
         return slot_write($urandom_range(15), $urandom_range(1439), $urandom());
      return eval_req($urandom_range(65535), $urandom_range(1439),
                      $urandom(), ($urandom_range(2) == 0) ? 0 : $urandom());
   endfunction

   // Random items with a fresh configuration every batch
   task automatic test_random(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int k = 0; k < count; k++) begin
         if (k % 30 == 0) begin
            drain();
            random_config();
         end
         send_item(random_item());
      end
      drain();
   endtask

   // Hold the receiver while evaluations keep coming, so the input stalls
   task automatic test_backpressure;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b1;
      for (int k = 0; k < 20; k++)
         send_item(eval_req($urandom_range(65535), $urandom_range(1439), 0, 0));
      drain();
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      rsp_ready    = 1'b0;
      err_cnt      = 0;
      cycle_cnt    = 0;
      hold_request = 1'b0;
      hold_left    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      sched_cfg = '{schedule_mode: 1'b0, week_day_mask: 7'd127, cycle_days: 5'd1,
                    cycle_anchor_day: 16'd0, slots_in_use: 5'd0, grace_window: 8'd30};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(180, 27, 88);
      test_random(180, 88, 27);
      test_random(180, 0, 0);
      if (err_cnt == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/dse_pkg.sv
hdl/dse_datapath.sv
hdl/dse_controller.sv
hdl/dose_schedule_evaluator.sv
bench/testbench.sv
